// ----- design/mvf_pkg.sv -----
// ---------------------------------------------------------------------------
// mvf_pkg: shared constants and types of the moving average filter
// Field widths, scaling constants and the item that travels through the queue.
// ---------------------------------------------------------------------------
package mvf_pkg;

  localparam int CODE_W         = 12;
  localparam int MV_W           = 13;
  localparam int MV_MAX         = 4995;

  // window length range and default
  localparam int WINDOW_DEFAULT = 100;
  localparam int WINDOW_MAX     = 1024;
  localparam int SLOT_MAX_W     = $clog2(WINDOW_MAX);

  // gain of 1.22 mV per code as a fixed point multiply and shift,
  // exact for every 12-bit code
  localparam int SCALE_SHIFT    = 20;
  localparam int SCALE_MUL_W    = 21;
  localparam logic [SCALE_MUL_W-1:0] SCALE_MUL = 21'd1279263;

  localparam int QUEUE_DEPTH    = 2;

  typedef struct packed {
    logic [MV_W-1:0]       mv;
    logic [SLOT_MAX_W-1:0] slot;
    logic                  old_used;
    logic                  emit;
  } mvf_item_t;

endpackage

// ----- design/mvf_ifs.sv -----
// ---------------------------------------------------------------------------
// mvf channel interfaces
// Valid/ready channels for converter codes and averaged results.
// ---------------------------------------------------------------------------
interface mvf_code_if import mvf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] adc_code;

  modport source (output valid, output adc_code, input ready);
  modport sink   (input valid, input adc_code, output ready);
endinterface

interface mvf_avg_if import mvf_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [MV_W-1:0] average_mv;

  modport source (output valid, output average_mv, input ready);
  modport sink   (input valid, input average_mv, output ready);
endinterface

// ----- design/mvf_front.sv -----
// ---------------------------------------------------------------------------
// mvf_front: input side of the moving average filter
// Scales each code to millivolts, assigns its ring slot and tags it.
// ---------------------------------------------------------------------------
module mvf_front import mvf_pkg::*; #(
  parameter int WINDOW = WINDOW_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  mvf_code_if.sink    codes,
  input  logic        full,
  output logic        push,
  output mvf_item_t   push_item
);

  localparam int SLOT_W = $clog2(WINDOW);
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int PROD_W = CODE_W + SCALE_MUL_W;

  logic [SLOT_W-1:0] slot;
  logic [FILL_W-1:0] fill;
  logic              window_full;
  logic [PROD_W-1:0] scaled;

  assign codes.ready = !full;
  assign push        = codes.valid && !full;
  assign window_full = (fill == FILL_W'(WINDOW));

  // mv = floor(code * 1.22)
  assign scaled = PROD_W'(codes.adc_code) * PROD_W'(SCALE_MUL);

  always_comb begin
    push_item.mv       = scaled[SCALE_SHIFT +: MV_W];
    push_item.slot     = SLOT_MAX_W'(slot);
    // the slot holds a real sample only once every slot has been written
    push_item.old_used = window_full;
    push_item.emit     = window_full || (fill == FILL_W'(WINDOW - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
      fill <= '0;
    end else if (push) begin
      slot <= (slot == SLOT_W'(WINDOW - 1)) ? '0 : slot + 1'b1;
      if (!window_full) begin
        fill <= fill + 1'b1;
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(WINDOW))
    else $error("fill level beyond window");

  a_slot_tracks_fill: assert property (@(posedge clk) disable iff (rst)
    !window_full |-> (FILL_W'(slot) == fill))
    else $error("slot out of step with fill level");

endmodule

// ----- design/mvf_queue.sv -----
// ---------------------------------------------------------------------------
// mvf_queue: short queue between front and back
// Registered first-in first-out buffer of tagged samples.
// ---------------------------------------------------------------------------
module mvf_queue import mvf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  mvf_item_t push_item,
  input  logic      pop,
  output logic      full,
  output logic      not_empty,
  output mvf_item_t head
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  mvf_item_t         entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < CNT_W'(QUEUE_DEPTH)) || pop)
    else $error("push into full queue");

endmodule

// ----- design/mvf_back.sv -----
// ---------------------------------------------------------------------------
// mvf_back: ring buffer, running sum and divide by window
// Pipeline that updates the sum per sample and forms the truncated mean.
// ---------------------------------------------------------------------------
module mvf_back import mvf_pkg::*; #(
  parameter int WINDOW = WINDOW_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        not_empty,
  input  mvf_item_t   head,
  output logic        pop,
  mvf_avg_if.source   averages
);

  localparam int SLOT_W = $clog2(WINDOW);
  localparam int SUM_W  = $clog2(WINDOW * MV_MAX + 1);
  localparam int PROD_W = 2 * SUM_W;
  // floor(2^SUM_W / WINDOW): estimate is low by at most one
  localparam logic [SUM_W-1:0] RECIP   = SUM_W'((64'(1) << SUM_W) / WINDOW);
  localparam logic [SUM_W-1:0] WIN_S   = SUM_W'(WINDOW);
  localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(WINDOW * MV_MAX);

  logic [MV_W-1:0]   ring [WINDOW];

  logic              adv;

  // read stage
  logic              b1_valid;
  logic [MV_W-1:0]   b1_mv;
  logic [SLOT_W-1:0] b1_slot;
  logic              b1_emit;
  logic              b1_old_used;
  logic [MV_W-1:0]   old_mv;

  // sum stage
  logic [SUM_W-1:0]  running_sum;
  logic [SUM_W-1:0]  running_sum_next;
  logic [MV_W-1:0]   old_val;
  logic              s_valid;
  logic [SUM_W-1:0]  s_sum;

  // reciprocal product stage
  logic              p_valid;
  logic [SUM_W-1:0]  p_sum;
  logic [PROD_W-1:0] p_prod;
  logic [MV_W-1:0]   quot_est;

  // estimate stage
  logic              e_valid;
  logic [SUM_W-1:0]  e_sum;
  logic [MV_W-1:0]   e_quot;
  logic [SUM_W-1:0]  e_qw;
  logic [SUM_W-1:0]  rem;

  // output register
  logic              o_valid;
  logic [MV_W-1:0]   o_avg;

  assign adv = !o_valid || averages.ready;
  assign pop = adv && not_empty;

  assign old_val          = b1_old_used ? old_mv : '0;
  assign running_sum_next = running_sum - SUM_W'(old_val) + SUM_W'(b1_mv);
  assign quot_est         = MV_W'(p_prod[PROD_W-1:SUM_W]);
  assign rem              = e_sum - e_qw;

  // ring memory: read at the queue head slot, write one stage later
  always_ff @(posedge clk) begin
    if (pop) begin
      old_mv <= ring[head.slot[SLOT_W-1:0]];
    end
    if (adv && b1_valid) begin
      ring[b1_slot] <= b1_mv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_mv       <= head.mv;
      b1_slot     <= head.slot[SLOT_W-1:0];
      b1_emit     <= head.emit;
      b1_old_used <= head.old_used;
      s_sum       <= running_sum_next;
      p_sum       <= s_sum;
      p_prod      <= PROD_W'(s_sum) * PROD_W'(RECIP);
      e_sum       <= p_sum;
      e_quot      <= quot_est;
      e_qw        <= SUM_W'(quot_est) * WIN_S;
      o_avg       <= (rem >= WIN_S) ? e_quot + 1'b1 : e_quot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid    <= 1'b0;
      s_valid     <= 1'b0;
      p_valid     <= 1'b0;
      e_valid     <= 1'b0;
      o_valid     <= 1'b0;
      running_sum <= '0;
    end else if (adv) begin
      b1_valid <= not_empty;
      s_valid  <= b1_valid && b1_emit;
      p_valid  <= s_valid;
      e_valid  <= p_valid;
      o_valid  <= e_valid;
      if (b1_valid) begin
        running_sum <= running_sum_next;
      end
    end
  end

  assign averages.valid      = o_valid;
  assign averages.average_mv = o_avg;

  a_sum_frozen_on_stall: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(running_sum))
    else $error("running sum moved during stall");

  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    running_sum <= SUM_MAX)
    else $error("running sum above window maximum");

endmodule

// ----- design/moving_average_mv_filter.sv -----
// ---------------------------------------------------------------------------
// moving_average_mv_filter: boxcar moving average of converter codes in mV
// Each code passes the queue, then the read, sum, product, estimate and output stages.
// Throughput: one code per cycle unless the output stalls, set by one ring read and write.
// The first WINDOW-1 codes after reset only fill the window and give no result.
// Reset (rst, synchronous): clears fill count, write slot, running sum and pipeline valids.
// The ring needs no clearing pass: slots not yet written are masked by the fill count.
// ---------------------------------------------------------------------------
module moving_average_mv_filter import mvf_pkg::*; #(
  parameter int WINDOW = WINDOW_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  mvf_code_if.sink   codes,
  mvf_avg_if.source  averages
);

  // front to queue
  logic      push;
  mvf_item_t push_item;
  logic      full;

  // queue to back
  logic      not_empty;
  logic      pop;
  mvf_item_t head;

  // front: scale each code by 1.22 mV, pick its ring slot and tag whether
  // the slot already holds a sample and whether this transfer makes a result
  mvf_front #(
    .WINDOW (WINDOW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .codes     (codes),
    .full      (full),
    .push      (push),
    .push_item (push_item)
  );

  // two-entry queue so an output stall does not reach the input in the same cycle
  mvf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head      (head)
  );

  // back: ring read, sum update with ring write, reciprocal multiply,
  // estimate times window, remainder correction into the output register;
  // the whole back pipeline holds while a result waits to be taken
  mvf_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (not_empty),
    .head      (head),
    .pop       (pop),
    .averages  (averages)
  );

endmodule
